// File: src/xoshiro256plus_generator_defines.svh
// Assertion macros used by the generator controller.
// Expects signals named clock and reset in the module that uses them.
`ifndef XOSHIRO256PLUS_GENERATOR_DEFINES_SVH
`define XOSHIRO256PLUS_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define X256P_ASSERT_IMP(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("x256p: %s failed", "lbl");

// Next-cycle implication, disabled during reset.
`define X256P_ASSERT_NXT(lbl, a, b) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("x256p: %s failed", "lbl");

`endif

// File: src/x256p_pkg.sv
// Shared types and constants of the xoshiro256+ generator.
// No dependencies; imported by the controller, the datapath and the top level.
package x256p_pkg;

   // Request op codes
   localparam logic [1:0] OP_NEXT  = 2'd0;
   localparam logic [1:0] OP_SEED  = 2'd1;
   localparam logic [1:0] OP_TRIAL = 2'd2;
   localparam logic [1:0] OP_HOLD  = 2'd3;

   // Seeder and mixer constants
   localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

   // State after reset
   localparam logic [63:0] RESET_W0 = 64'h0;
   localparam logic [63:0] RESET_W1 = 64'he220a8397b1dcdaf;
   localparam logic [63:0] RESET_W2 = 64'ha706dd2f4d197e6f;
   localparam logic [63:0] RESET_W3 = 64'h238275bc38fcbe91;

   // Shift and rotate amounts
   localparam int STEP_SHL  = 17;
   localparam int STEP_ROT  = 45;
   localparam int MIX_SHR_A = 30;
   localparam int MIX_SHR_B = 27;
   localparam int MIX_SHR_C = 31;

   // Three mixes per seed: index of the last one
   localparam logic [1:0] LAST_MIX = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP_A,
      ST_MUL_LL,
      ST_MUL_LH,
      ST_MUL_HL,
      ST_PREP_B,
      ST_FINISH,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_NEXT,
      DP_HOLD,
      DP_SEED_LOAD,
      DP_PREP_A,
      DP_MUL_LL,
      DP_MUL_LH,
      DP_MUL_HL,
      DP_PREP_B,
      DP_FINISH,
      DP_RESULT
   } dp_op_type;

   // Command from controller to datapath
   typedef struct packed {
      dp_op_type  op;
      logic       const_sel;  // 0: first mix multiplier, 1: second
      logic [1:0] mix_idx;    // which of the three mixes runs
      logic       commit;     // result replaces the generator state
   } dp_cmd_type;

endpackage

// File: src/x256p_ctrl.sv
// Sequencer of the xoshiro256+ generator: handshakes and seed micro-steps.
// Depends on x256p_pkg and the assertion macros header.
`include "xoshiro256plus_generator_defines.svh"

module x256p_ctrl
   import x256p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     mix_cnt_ff, mix_cnt_in;
   logic           phase_ff, phase_in;
   logic           commit_ff, commit_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic out_free;
   logic accept;
   logic load_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and sequencing counters
   always_comb begin
      state_in   = state_ff;
      mix_cnt_in = mix_cnt_ff;
      phase_in   = phase_ff;
      commit_in  = commit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_SEED || req_op == OP_TRIAL)) begin
               state_in   = ST_PREP_A;
               mix_cnt_in = '0;
               phase_in   = 1'b0;
               commit_in  = (req_op == OP_SEED);
            end
         end
         ST_PREP_A: state_in = ST_MUL_LL;
         ST_MUL_LL: state_in = ST_MUL_LH;
         ST_MUL_LH: state_in = ST_MUL_HL;
         ST_MUL_HL: state_in = phase_ff ? ST_FINISH : ST_PREP_B;
         ST_PREP_B: begin
            state_in = ST_MUL_LL;
            phase_in = 1'b1;
         end
         ST_FINISH: begin
            phase_in = 1'b0;
            if (mix_cnt_ff == LAST_MIX) begin
               state_in = ST_DONE;
            end else begin
               state_in   = ST_PREP_A;
               mix_cnt_in = mix_cnt_ff + 2'd1;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath command and output-register load
   always_comb begin
      cmd.op        = DP_IDLE;
      cmd.const_sel = phase_ff;
      cmd.mix_idx   = mix_cnt_ff;
      cmd.commit    = commit_ff;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_NEXT: begin
                     cmd.op   = DP_NEXT;
                     load_rsp = 1'b1;
                  end
                  OP_HOLD: begin
                     cmd.op   = DP_HOLD;
                     load_rsp = 1'b1;
                  end
                  default: cmd.op = DP_SEED_LOAD;
               endcase
            end
         end
         ST_PREP_A: cmd.op = DP_PREP_A;
         ST_MUL_LL: cmd.op = DP_MUL_LL;
         ST_MUL_LH: cmd.op = DP_MUL_LH;
         ST_MUL_HL: cmd.op = DP_MUL_HL;
         ST_PREP_B: cmd.op = DP_PREP_B;
         ST_FINISH: cmd.op = DP_FINISH;
         ST_DONE: begin
            if (out_free) begin
               cmd.op   = DP_RESULT;
               load_rsp = 1'b1;
            end
         end
         default: cmd.op = DP_IDLE;
      endcase
   end

   // Output word valid flag
   always_comb begin
      priority if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mix_cnt_ff   <= '0;
         phase_ff     <= 1'b0;
         commit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mix_cnt_ff   <= mix_cnt_in;
         phase_ff     <= phase_in;
         commit_ff    <= commit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `X256P_ASSERT_IMP(a_ready_only_idle, req_ready, state_ff == ST_IDLE)
   `X256P_ASSERT_NXT(a_done_loads_rsp, state_ff == ST_DONE && out_free, rsp_valid_ff)
   `X256P_ASSERT_NXT(a_seed_starts, accept && (req_op == OP_SEED || req_op == OP_TRIAL), state_ff == ST_PREP_A && mix_cnt_ff == 2'd0)
   `X256P_ASSERT_IMP(a_mix_cnt_range, state_ff != ST_IDLE, mix_cnt_ff != 2'd3)

endmodule

// File: src/x256p_datapath.sv
// Datapath of the xoshiro256+ generator: state words, seed mixer, output word.
// Depends on x256p_pkg; driven by commands from x256p_ctrl.
module x256p_datapath
   import x256p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   input  logic [63:0] req_seed_value,
   output logic [63:0] rsp_value
);

   logic [63:0] gen_ff [4];
   logic [63:0] gen_in [4];
   logic [63:0] tw_ff  [4];
   logic [63:0] tw_in  [4];
   logic [63:0] zin_ff, zin_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   logic [63:0] n0, n1, n2, n3, shl_t;
   logic [63:0] mul_const, mix_out, seed_sum;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [1:0]  tw_idx;

   // One xoshiro256 step
   always_comb begin
      shl_t = gen_ff[1] << STEP_SHL;
      n2    = gen_ff[2] ^ gen_ff[0];
      n3    = gen_ff[3] ^ gen_ff[1];
      n1    = gen_ff[1] ^ n2;
      n0    = gen_ff[0] ^ n3;
   end

   // Shared 32x32 multiplier, one partial product per pass
   assign mul_const = cmd.const_sel ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a     = (cmd.op == DP_MUL_HL) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b     = (cmd.op == DP_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
   assign mul_p     = 64'(mul_a) * 64'(mul_b);

   assign mix_out  = prod_ff ^ (prod_ff >> MIX_SHR_C);
   assign seed_sum = req_seed_value + GOLDEN_INC;
   assign tw_idx   = cmd.mix_idx + 2'd1;

   always_comb begin
      gen_in       = gen_ff;
      tw_in        = tw_ff;
      zin_in       = zin_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      rsp_value_in = rsp_value_ff;
      unique case (cmd.op)
         DP_NEXT: begin
            rsp_value_in = gen_ff[0] + gen_ff[3];
            gen_in[0]    = n0;
            gen_in[1]    = n1;
            gen_in[2]    = n2 ^ shl_t;
            gen_in[3]    = (n3 << STEP_ROT) | (n3 >> (64 - STEP_ROT));
         end
         DP_HOLD: rsp_value_in = gen_ff[0] + gen_ff[3];
         DP_SEED_LOAD: begin
            tw_in[0] = seed_sum;
            zin_in   = seed_sum;
         end
         DP_PREP_A: x_in = zin_ff ^ (zin_ff >> MIX_SHR_A);
         DP_MUL_LL: prod_in = mul_p;
         DP_MUL_LH, DP_MUL_HL: begin
            prod_in = {prod_ff[63:32] + mul_p[31:0], prod_ff[31:0]};
         end
         DP_PREP_B: x_in = prod_ff ^ (prod_ff >> MIX_SHR_B);
         DP_FINISH: begin
            // Last mix is stored bare, earlier ones keep the increment
            if (cmd.mix_idx == LAST_MIX) begin
               tw_in[tw_idx] = mix_out;
            end else begin
               tw_in[tw_idx] = mix_out + GOLDEN_INC;
               zin_in        = mix_out + GOLDEN_INC;
            end
         end
         DP_RESULT: begin
            rsp_value_in = tw_ff[0] + tw_ff[3];
            if (cmd.commit) gen_in = tw_ff;
         end
         default: ;
      endcase
   end

   // Generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff[0] <= RESET_W0;
         gen_ff[1] <= RESET_W1;
         gen_ff[2] <= RESET_W2;
         gen_ff[3] <= RESET_W3;
      end else begin
         gen_ff <= gen_in;
      end
   end

   // Working registers and output word
   always_ff @(posedge clock) begin
      tw_ff        <= tw_in;
      zin_ff       <= zin_in;
      x_ff         <= x_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_value = rsp_value_ff;

endmodule

// File: src/xoshiro256plus_generator.sv
// xoshiro256+ generator. Next (op 0) and hold (op 3): word registered on acceptance,
// one word per cycle while the output is free. Seed (op 1) and trial (op 2): three
// mixes run on the shared 32x32 multiplier, six 64-bit products in three passes each,
// and no request is taken until the word is loaded. Synchronous active-high
// reset loads the fixed state words and empties the output register.
// Depends on x256p_pkg, x256p_ctrl and x256p_datapath.
module xoshiro256plus_generator
   import x256p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value
);

   dp_cmd_type cmd;

   x256p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   x256p_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_seed_value (req_seed_value),
      .rsp_value      (rsp_value)
   );

endmodule

// File: tb/xoshiro256plus_generator_tb.sv
// Self-checking testbench for the xoshiro256+ generator: next, seed, trial and hold requests,
// checked against an in-bench predictor of the four state words.
// Depends on x256p_pkg and xoshiro256plus_generator.
module xoshiro256plus_generator_tb;
   import x256p_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_WORDS  = 700;
   localparam int HOLDOFF_AT    = 250;   // results seen before the long receiver hold-off
   localparam int HOLDOFF_LEN   = 150;
   localparam int IDLE_PERCENT  = 10;

   typedef logic [3:0][63:0] gen_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] seed_value;
   } gen_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_NEXT;
   logic [63:0] req_seed_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;

   gen_request_type pending_words[$];
   logic [63:0]     expected_values[$];
   gen_state_type   gen_state;

   logic            req_taken = 1'b0;
   int              words_sent = 0;
   int              values_seen = 0;
   int              error_count = 0;
   int              op_counts[4] = '{default: 0};
   int              holdoff_left = 0;
   bit              holdoff_done = 1'b0;
   int              quiet_cycles = 0;
   gen_request_type drive_word;
   logic [63:0]     oldest_value;

   xoshiro256plus_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_seed_value (req_seed_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // splitmix64 finalizer
   function automatic logic [63:0] splitmix_finalize(input logic [63:0] z);
      logic [63:0] acc;
      acc = (z ^ (z >> MIX_SHR_A)) * MIX_MUL_A;
      acc = (acc ^ (acc >> MIX_SHR_B)) * MIX_MUL_B;
      return acc ^ (acc >> MIX_SHR_C);
   endfunction

   // Seeder variant: every earlier word keeps the golden-ratio increment
   function automatic gen_state_type expand_seed(input logic [63:0] seed);
      gen_state_type words;
      words[0] = seed + GOLDEN_INC;
      words[1] = splitmix_finalize(words[0]) + GOLDEN_INC;
      words[2] = splitmix_finalize(words[1]) + GOLDEN_INC;
      words[3] = splitmix_finalize(words[2]);
      return words;
   endfunction

   // Expected value for one request; updates the predicted state words
   function automatic logic [63:0] predict_value(input logic [1:0] op, input logic [63:0] seed);
      gen_state_type fresh;
      logic [63:0]   shifted;
      logic [63:0]   result;
      result = gen_state[0] + gen_state[3];
      case (op)
         OP_NEXT: begin
            shifted = gen_state[1] << STEP_SHL;
            gen_state[2] ^= gen_state[0];
            gen_state[3] ^= gen_state[1];
            gen_state[1] ^= gen_state[2];
            gen_state[0] ^= gen_state[3];
            gen_state[2] ^= shifted;
            gen_state[3] = (gen_state[3] << STEP_ROT) | (gen_state[3] >> (64 - STEP_ROT));
         end
         OP_SEED: begin
            gen_state = expand_seed(seed);
            result = gen_state[0] + gen_state[3];
         end
         OP_TRIAL: begin
            fresh = expand_seed(seed);
            result = fresh[0] + fresh[3];
         end
         default: begin
            // hold: report only
         end
      endcase
      return result;
   endfunction

   // Mostly full-random seeds, sometimes the extremes
   function automatic logic [63:0] random_seed();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic queue_word(input logic [1:0] op, input logic [63:0] seed);
      gen_request_type item;
      item.op = op;
      item.seed_value = seed;
      pending_words.push_back(item);
   endtask

   // Monitor: check results against the oldest expectation, predict each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            values_seen++;
            if (expected_values.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual %h", $time, rsp_value);
            end else begin
               oldest_value = expected_values.pop_front();
               if (rsp_value !== oldest_value) begin
                  error_count++;
                  $display("%0t: value mismatch: expected %h, actual %h",
                           $time, oldest_value, rsp_value);
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_values.push_back(predict_value(req_op, req_seed_value));
            op_counts[req_op]++;
            words_sent++;
         end
      end
   end

   // Driver: offer the next pending word, with random gaps outside the quiet window
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0 &&
             ((words_sent >= 300 && words_sent < 450) ||
              $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            drive_word = pending_words.pop_front();
            req_valid      <= 1'b1;
            req_op         <= drive_word.op;
            req_seed_value <= drive_word.seed_value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, one long hold-off, one stretch with no stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (!holdoff_done && values_seen >= HOLDOFF_AT) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_LEN - 1;
         rsp_ready <= 1'b0;
      end else if (values_seen >= 400 && values_seen < 550) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles at %0t", quiet_cycles, $time);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          pick;
      logic [1:0]  op_pick;

      gen_state = {RESET_W3, RESET_W2, RESET_W1, RESET_W0};

      // Directed: reset state, ignored seed field, hold, extremes, wrap of s + g
      queue_word(OP_NEXT,  '0);
      queue_word(OP_NEXT,  '1);
      queue_word(OP_NEXT,  64'h0123_4567_89ab_cdef);
      queue_word(OP_HOLD,  '1);
      queue_word(OP_HOLD,  64'h5a5a_a5a5_f0f0_0f0f);
      queue_word(OP_TRIAL, '0);
      queue_word(OP_TRIAL, '1);
      queue_word(OP_NEXT,  '0);
      queue_word(OP_SEED,  '0);
      queue_word(OP_NEXT,  '0);
      queue_word(OP_NEXT,  '1);
      queue_word(OP_SEED,  '1);
      queue_word(OP_NEXT,  '0);
      queue_word(OP_HOLD,  '0);
      queue_word(OP_SEED,  64'h8000_0000_0000_0000);
      queue_word(OP_SEED,  64'h1);
      // seed that makes s + g wrap to zero
      queue_word(OP_TRIAL, 64'h0 - GOLDEN_INC);
      queue_word(OP_SEED,  64'h0 - GOLDEN_INC);
      queue_word(OP_NEXT,  '0);
      queue_word(OP_TRIAL, {$urandom, $urandom});
      queue_word(OP_NEXT,  '0);
      queue_word(OP_HOLD,  '1);

      // Random: mostly next, with seeds, trials and holds mixed in
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)      op_pick = OP_NEXT;
         else if (pick < 77) op_pick = OP_SEED;
         else if (pick < 89) op_pick = OP_TRIAL;
         else                op_pick = OP_HOLD;
         queue_word(op_pick, random_seed());
      end

      // Synchronous reset, released on a falling clock edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for all stimulus, then all results, then let the block settle
      while (pending_words.size() != 0 || req_valid) @(negedge clock);
      while (expected_values.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_values.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, expected_values.size());
      end

      $display("Sent %0d words: %0d next, %0d seed, %0d trial, %0d hold.",
               words_sent, op_counts[OP_NEXT], op_counts[OP_SEED],
               op_counts[OP_TRIAL], op_counts[OP_HOLD]);
      $display("Checked %0d results under random stalls and one long output hold-off.",
               values_seen);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/x256p_pkg.sv
src/x256p_ctrl.sv
src/x256p_datapath.sv
src/xoshiro256plus_generator.sv
tb/xoshiro256plus_generator_tb.sv
